### src/chunked_adler32_xor_fold_core_assert.svh
// Assertion macros shared by the checksum core.
`ifndef CHUNKED_ADLER32_XOR_FOLD_CORE_ASSERT_SVH
`define CHUNKED_ADLER32_XOR_FOLD_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CADL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("checksum core: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define CADL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("checksum core: next-cycle check failed");

`endif

### src/cadl_pkg.sv
`default_nettype none

package cadl_pkg;

	// Chunk length in bytes and the width of the fill counter that reaches it
	localparam int unsigned CHUNK_BYTES = 67108864;
	localparam int unsigned FILL_W = $clog2(CHUNK_BYTES + 1);

	// Adler-32 modulus
	localparam logic [15:0] ADLER_MOD = 16'd65521;

	// Queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCW = $clog2(QDEPTH + 1);

	// One classified byte on its way to the back end
	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
		logic       last_byte;
	} entry_t;

	// Queue status seen by the front end and the checks
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Add two residues and reduce once by the modulus
	function automatic logic [15:0] mod_add(input logic [15:0] x, input logic [15:0] y);
		logic [16:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, ADLER_MOD}) begin
			s = s - {1'b0, ADLER_MOD};
		end
		return s[15:0];
	endfunction

endpackage

`default_nettype wire

### src/cadl_front.sv
`default_nettype none

module cadl_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	input  wire cadl_pkg::qstat_t     q_stat,
	output logic                      push,
	output cadl_pkg::entry_t          push_entry
);

	logic [cadl_pkg::FILL_W-1:0] fill_q;
	logic [cadl_pkg::FILL_W-1:0] fill_next;
	logic                        full;

	// Take a request whenever the queue has room
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	// Classify the byte: does it close its chunk?
	assign fill_next = fill_q + cadl_pkg::FILL_W'(1);
	assign full      = fill_next >= cadl_pkg::FILL_W'(cadl_pkg::CHUNK_BYTES);

	always_comb begin
		push_entry.data_byte = data_byte;
		push_entry.chunk_end = full || last_byte;
		push_entry.last_byte = last_byte;
	end

	// Advance the chunk fill, restart it at a chunk or file boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			if (full || last_byte) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_next;
			end
		end
	end

endmodule

`default_nettype wire

### src/cadl_fifo.sv
`default_nettype none

module cadl_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire cadl_pkg::entry_t push_entry,
	input  wire logic             pop,
	output cadl_pkg::entry_t      head,
	output cadl_pkg::qstat_t      q_stat
);

	cadl_pkg::entry_t             mem_q [cadl_pkg::QDEPTH];
	logic [cadl_pkg::QAW-1:0]     wr_ptr_q;
	logic [cadl_pkg::QAW-1:0]     rd_ptr_q;
	logic [cadl_pkg::QCW-1:0]     count_q;

	// Step a pointer with wrap at the queue depth
	function automatic logic [cadl_pkg::QAW-1:0] ptr_inc(input logic [cadl_pkg::QAW-1:0] p);
		if (p == cadl_pkg::QAW'(cadl_pkg::QDEPTH - 1)) begin
			return '0;
		end
		return p + cadl_pkg::QAW'(1);
	endfunction

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = count_q == cadl_pkg::QCW'(cadl_pkg::QDEPTH);
	assign q_stat.empty = count_q == '0;

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + cadl_pkg::QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - cadl_pkg::QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/cadl_back.sv
`default_nettype none

module cadl_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cadl_pkg::entry_t head,
	input  wire cadl_pkg::qstat_t q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [31:0]           checksum
);

	logic [15:0] sum_a_q;
	logic [15:0] sum_b_q;
	logic [31:0] fold_q;
	logic        out_valid_q;
	logic [31:0] checksum_q;
	logic [15:0] a_new;
	logic [15:0] b_new;
	logic [31:0] fold_new;
	logic        slot_free;

	// Pop unless a final byte would land on a result still waiting
	assign slot_free = !out_valid_q || out_ready;
	assign pop       = !q_stat.empty && (!head.last_byte || slot_free);

	// Per-byte Adler update and chunk fold
	assign a_new    = cadl_pkg::mod_add(sum_a_q, {8'd0, head.data_byte});
	assign b_new    = cadl_pkg::mod_add(sum_b_q, a_new);
	assign fold_new = fold_q ^ {b_new, a_new};

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

	// Hold sums and fold, restart at boundaries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= 16'd1;
			sum_b_q <= 16'd0;
			fold_q  <= '0;
		end else if (pop) begin
			if (head.chunk_end) begin
				sum_a_q <= 16'd1;
				sum_b_q <= 16'd0;
				fold_q  <= head.last_byte ? 32'd0 : fold_new;
			end else begin
				sum_a_q <= a_new;
				sum_b_q <= b_new;
			end
		end
	end

	// Output register: load on the final byte, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last_byte) begin
			checksum_q <= fold_new;
		end
	end

endmodule

`default_nettype wire

### src/chunked_adler32_xor_fold_core.sv
// Chunked Adler-32 with XOR fold.
// Input channel (in_valid/in_ready): one file byte per request, data_byte,
// with last_byte high on the final byte of the file. The file is cut into
// chunks of CHUNK_BYTES bytes; each chunk gets a standard Adler-32 and the
// chunk values are XOR-folded.
// Output channel (out_valid/out_ready): one checksum per file, the fold of
// all its chunks including the final (possibly short) one.
// Throughput: one byte per cycle while the back end is not held by a
// waiting result, set by the combinational Adler update in the back end.
// A final byte is queued, popped at the head, then loads the output register.
// A two-entry queue splits the front (chunk counter) from the back (sums);
// bytes keep flowing while a checksum waits. If the receiver stalls, the
// back end stops only at the next file's final byte and the queue fills,
// then in_ready drops.
// Reset: all sums, the chunk count and the fold return to their start
// values, the queue empties and no result is pending.
`default_nettype none

`include "chunked_adler32_xor_fold_core_assert.svh"

module chunked_adler32_xor_fold_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      checksum
);

	cadl_pkg::entry_t push_entry;
	cadl_pkg::entry_t head;
	cadl_pkg::qstat_t q_stat;
	logic             push;
	logic             pop;

	cadl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	cadl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	cadl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.checksum  (checksum)
	);

	// Queue is never full and empty at once
	`CADL_ASSERT_NOW(a_qstat_sane, clk, arst_n, 1'b1, !(q_stat.full && q_stat.empty))
	// Back end pops only a present entry
	`CADL_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, !q_stat.empty)
	// A waiting result is never overwritten by a final byte
	`CADL_ASSERT_NOW(a_no_clobber, clk, arst_n, out_valid && !out_ready,
		!(pop && head.last_byte))
	// A final byte popped always raises a result next cycle
	`CADL_ASSERT_NEXT(a_last_emits, clk, arst_n, pop && head.last_byte, out_valid)

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

// Tracks the running Adler sums of the file in flight and holds the folded
// checksums still owed by the core.
class adler_fold_board;
	logic [15:0] run_a;
	logic [15:0] run_b;
	logic [31:0] bytes_in_chunk;
	logic [31:0] folded;
	logic [31:0] owed_sums[$];
	int          errors;

	function new();
		errors = 0;
		start_file();
	endfunction

	function void start_file();
		run_a = 16'd1;
		run_b = 16'd0;
		bytes_in_chunk = 0;
		folded = 0;
	endfunction

	// Add and bring back into the residue range with one subtract
	function logic [15:0] add_mod(input logic [15:0] x, input logic [15:0] y);
		logic [16:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, cadl_pkg::ADLER_MOD}) begin
			s = s - {1'b0, cadl_pkg::ADLER_MOD};
		end
		return s[15:0];
	endfunction

	// Advance the sums by one accepted request
	function void note_byte(input logic [7:0] b, input logic fin);
		run_a = add_mod(run_a, {8'd0, b});
		run_b = add_mod(run_b, run_a);
		bytes_in_chunk = bytes_in_chunk + 1;
		// Fold a full chunk, or the short tail at the end of the file
		if (bytes_in_chunk >= cadl_pkg::CHUNK_BYTES || fin) begin
			folded = folded ^ {run_b, run_a};
			run_a = 16'd1;
			run_b = 16'd0;
			bytes_in_chunk = 0;
		end
		if (fin) begin
			owed_sums.push_back(folded);
			start_file();
		end
	endfunction

	task report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Compare a delivered checksum with the oldest one owed
	task check_sum(input logic [31:0] got);
		logic [31:0] want;
		if (owed_sums.size() == 0) begin
			report($sformatf("checksum %08h with no file pending", got));
		end else begin
			want = owed_sums.pop_front();
			if (got !== want) begin
				report($sformatf("checksum %08h, expected %08h", got, want));
			end
		end
	endtask
endclass

module testbench;

	localparam int unsigned RANDOM_ITEMS = 1130;
	localparam int unsigned CALM_ITEMS = 150;
	localparam int unsigned STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_ready = 1'b1;
	logic        in_ready;
	logic        out_valid;
	logic [31:0] checksum;

	logic        calm = 1'b0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;

	adler_fold_board sb = new();

	chunked_adler32_xor_fold_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.checksum  (checksum)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the result channel in short bursts, except near the end
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check every delivered checksum
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_sum(checksum);
		end
	end

	// Give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one byte, maybe after a short gap, and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, fin);
	endtask

	// Drop the request and wait until every owed checksum has come back
	task automatic hold_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_sums.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned flen;
		int unsigned style;
		logic        paused;
		logic [7:0]  b;

		sent = 0;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-byte files at both byte extremes
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// Walk a single set bit through the byte
		for (int i = 0; i < 8; i++) begin
			send_byte(8'h01 << i, i == 7);
		end
		// Ten-byte all-ones file; the B sum stays below the modulus
		for (int i = 0; i < 10; i++) begin
			send_byte(8'hff, i == 9);
		end
		// Back-to-back short files with alternating bits
		send_byte(8'h55, 1'b1);
		send_byte(8'haa, 1'b1);
		hold_for_drain();

		// Random files: mostly short, some all-ones long enough to wrap A
		while (sent < RANDOM_ITEMS) begin
			calm = (sent + CALM_ITEMS > RANDOM_ITEMS);
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				hold_for_drain();
				paused = 1'b1;
			end
			style = $urandom_range(0, 19);
			if (style == 0) begin
				flen = $urandom_range(258, 320);
			end else if (style < 5) begin
				flen = $urandom_range(17, 60);
			end else begin
				flen = $urandom_range(1, 16);
			end
			for (int i = 0; i < flen; i++) begin
				if (style == 0 || style == 5) begin
					b = 8'hff;
				end else if (style == 6) begin
					b = $urandom_range(0, 1) ? 8'hff : 8'h00;
				end else begin
					b = 8'($urandom_range(0, 255));
				end
				send_byte(b, i == flen - 1);
			end
			sent = sent + flen;
		end

		hold_for_drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### files.f
+incdir+src
src/cadl_pkg.sv
src/cadl_front.sv
src/cadl_fifo.sv
src/cadl_back.sv
src/chunked_adler32_xor_fold_core.sv
tb/testbench.sv
